// ===== rtl/apbo_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// APNG blend-over package
// Shared types and constants for the pixel compositing pipeline.
// ----------------------------------------------------------------------------
package apbo_pkg;

  // One 8-bit color or alpha channel.
  typedef logic [7:0] chan_t;

  // BGRA pixel as it travels through the pipeline.
  typedef struct packed {
    chan_t blue;
    chan_t green;
    chan_t red;
    chan_t alpha;
  } pixel_t;

  // Alpha codes with a special meaning.
  localparam chan_t ALPHA_OPAQUE = 8'd255;
  localparam chan_t ALPHA_CLEAR  = 8'd0;

  // Color channels that go through the divider: blue, green, red.
  localparam int COLOR_CHANS = 3;
  localparam int CH_BLUE     = 0;
  localparam int CH_GREEN    = 1;
  localparam int CH_RED      = 2;

  // Weight and numerator widths and the divider stage count.
  localparam int WGT_W = 16;            // u, v and u+v
  localparam int NUM_W = 24;            // s*u + d*v
  localparam int DIV_STAGES = 8;        // one quotient bit per stage

  typedef logic [WGT_W-1:0] wgt_t;
  typedef logic [NUM_W-1:0] num_t;

endpackage

// ===== rtl/apng_pixel_blend_over_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// APNG pixel blend-over compositor
// Composites one frame pixel onto one canvas pixel per clock while the output is not held, BGRA 8-bit.
// ----------------------------------------------------------------------------
// The block takes one pixel pair per clock and presents the composited canvas
// pixels on the output in order. Each pixel passes twelve register stages:
// three that classify the pixel, form the weights and build the numerators,
// eight of the per-channel restoring divider, which resolves one quotient bit
// per stage, and the output register. The whole pipeline holds while a
// finished result waits on out_ready, so in_ready follows the output side.
// The blend_over register (reset 1) selects source copy (0) or blend over the
// canvas (1); it is written by a cfg_valid/cfg_ready transfer, always ready.
module apng_pixel_blend_over_top (
  input  logic           clk,
  input  logic           rst_n,
  // Configuration
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_blend_over,
  // Input pixel pair
  input  logic           in_valid,
  output logic           in_ready,
  input  apbo_pkg::chan_t in_src_blue,
  input  apbo_pkg::chan_t in_src_green,
  input  apbo_pkg::chan_t in_src_red,
  input  apbo_pkg::chan_t in_src_alpha,
  input  apbo_pkg::chan_t in_dst_blue,
  input  apbo_pkg::chan_t in_dst_green,
  input  apbo_pkg::chan_t in_dst_red,
  input  apbo_pkg::chan_t in_dst_alpha,
  // Composited pixel
  output logic           out_valid,
  input  logic           out_ready,
  output apbo_pkg::chan_t out_blue,
  output apbo_pkg::chan_t out_green,
  output apbo_pkg::chan_t out_red,
  output apbo_pkg::chan_t out_alpha
);
  import apbo_pkg::*;

  // Pipeline advance: every stage moves when the output is free or taken.
  logic adv;
  logic blend_over_r;

  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  // Mode register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_over_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      blend_over_r <= cfg_blend_over;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: classify the pixel and form the weights u and v.
  // --------------------------------------------------------------------------
  logic   s1_valid_r;
  logic   s1_blend_r, s1_blend_nxt;
  pixel_t s1_pix_r, s1_pix_nxt;
  chan_t  s1_sc_r [COLOR_CHANS];
  chan_t  s1_dc_r [COLOR_CHANS];
  wgt_t   s1_u_r, s1_u_nxt;
  wgt_t   s1_v_r, s1_v_nxt;
  logic   copy_src, keep_dst;
  pixel_t src_pix, dst_pix;
  chan_t  inv_sa;

  always_comb begin
    src_pix  = '{blue: in_src_blue, green: in_src_green, red: in_src_red,
                 alpha: in_src_alpha};
    dst_pix  = '{blue: in_dst_blue, green: in_dst_green, red: in_dst_red,
                 alpha: in_dst_alpha};
    // Source wins in copy mode, when opaque, or when not clear over a clear canvas.
    copy_src = !blend_over_r || (in_src_alpha == ALPHA_OPAQUE) ||
               ((in_src_alpha != ALPHA_CLEAR) && (in_dst_alpha == ALPHA_CLEAR));
    keep_dst = (in_src_alpha == ALPHA_CLEAR);
    s1_blend_nxt = !copy_src && !keep_dst;
    s1_pix_nxt   = copy_src ? src_pix : dst_pix;
    inv_sa       = ALPHA_OPAQUE - in_src_alpha;
    // u = sa * 255 as a shift and subtract; v = (255 - sa) * da.
    s1_u_nxt = {in_src_alpha, 8'd0} - {8'd0, in_src_alpha};
    s1_v_nxt = wgt_t'(inv_sa) * wgt_t'(in_dst_alpha);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_blend_r         <= s1_blend_nxt;
      s1_pix_r           <= s1_pix_nxt;
      s1_u_r             <= s1_u_nxt;
      s1_v_r             <= s1_v_nxt;
      s1_sc_r[CH_BLUE]   <= in_src_blue;
      s1_sc_r[CH_GREEN]  <= in_src_green;
      s1_sc_r[CH_RED]    <= in_src_red;
      s1_dc_r[CH_BLUE]   <= in_dst_blue;
      s1_dc_r[CH_GREEN]  <= in_dst_green;
      s1_dc_r[CH_RED]    <= in_dst_red;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: weighted products per channel and the weight sum.
  // --------------------------------------------------------------------------
  logic   s2_valid_r;
  logic   s2_blend_r;
  pixel_t s2_pix_r;
  wgt_t   s2_sum_r, s2_sum_nxt;
  num_t   s2_ps_r [COLOR_CHANS];
  num_t   s2_pd_r [COLOR_CHANS];
  num_t   s2_ps_nxt [COLOR_CHANS];
  num_t   s2_pd_nxt [COLOR_CHANS];

  always_comb begin
    s2_sum_nxt = s1_u_r + s1_v_r;
    for (int c = 0; c < COLOR_CHANS; c++) begin
      s2_ps_nxt[c] = num_t'(s1_sc_r[c]) * num_t'(s1_u_r);
      s2_pd_nxt[c] = num_t'(s1_dc_r[c]) * num_t'(s1_v_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_blend_r <= s1_blend_r;
      s2_pix_r   <= s1_pix_r;
      s2_sum_r   <= s2_sum_nxt;
      s2_ps_r    <= s2_ps_nxt;
      s2_pd_r    <= s2_pd_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: numerators and the blended alpha, sum / 255.
  // --------------------------------------------------------------------------
  logic             s3_valid_r;
  logic             s3_blend_r;
  pixel_t           s3_pix_r, s3_pix_nxt;
  wgt_t             s3_sum_r;
  num_t             s3_num_r [COLOR_CHANS];
  num_t             s3_num_nxt [COLOR_CHANS];
  logic [WGT_W:0]   alpha_acc;

  always_comb begin
    for (int c = 0; c < COLOR_CHANS; c++) begin
      s3_num_nxt[c] = s2_ps_r[c] + s2_pd_r[c];
    end
    // Exact floor(x / 255) for x up to 65025, the largest weight sum: (x + 1 + (x >> 8)) >> 8.
    alpha_acc  = {1'b0, s2_sum_r} + (WGT_W+1)'(1) + {9'd0, s2_sum_r[WGT_W-1:8]};
    s3_pix_nxt = s2_pix_r;
    if (s2_blend_r) begin
      s3_pix_nxt.alpha = alpha_acc[15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_blend_r <= s2_blend_r;
      s3_pix_r   <= s3_pix_nxt;
      s3_sum_r   <= s2_sum_r;
      s3_num_r   <= s3_num_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Divider: restoring division, one quotient bit per stage, MSB first.
  // The quotient is known to fit in 8 bits, so the first stage tries sum << 7.
  // --------------------------------------------------------------------------
  logic   dv_valid_r [DIV_STAGES];
  logic   dv_blend_r [DIV_STAGES];
  pixel_t dv_pix_r   [DIV_STAGES];
  wgt_t   dv_sum_r   [DIV_STAGES];
  num_t   dv_rem_r   [DIV_STAGES][COLOR_CHANS];
  chan_t  dv_quo_r   [DIV_STAGES][COLOR_CHANS];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    localparam int BIT = DIV_STAGES - 1 - j;

    logic   valid_in, blend_in;
    pixel_t pix_in;
    wgt_t   sum_in;
    num_t   rem_in [COLOR_CHANS];
    chan_t  quo_in [COLOR_CHANS];
    num_t   dvs;
    num_t   rem_nxt [COLOR_CHANS];
    chan_t  quo_nxt [COLOR_CHANS];

    // Stage input comes from the numerator stage or the previous bit.
    if (j == 0) begin : g_first
      always_comb begin
        valid_in = s3_valid_r;
        blend_in = s3_blend_r;
        pix_in   = s3_pix_r;
        sum_in   = s3_sum_r;
        for (int c = 0; c < COLOR_CHANS; c++) begin
          rem_in[c] = s3_num_r[c];
          quo_in[c] = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        valid_in = dv_valid_r[j-1];
        blend_in = dv_blend_r[j-1];
        pix_in   = dv_pix_r[j-1];
        sum_in   = dv_sum_r[j-1];
        for (int c = 0; c < COLOR_CHANS; c++) begin
          rem_in[c] = dv_rem_r[j-1][c];
          quo_in[c] = dv_quo_r[j-1][c];
        end
      end
    end

    // Trial subtract of the shifted divisor on each channel.
    always_comb begin
      dvs = {{(NUM_W-WGT_W){1'b0}}, sum_in} << BIT;
      for (int c = 0; c < COLOR_CHANS; c++) begin
        if (rem_in[c] >= dvs) begin
          rem_nxt[c] = rem_in[c] - dvs;
          quo_nxt[c] = {quo_in[c][6:0], 1'b1};
        end else begin
          rem_nxt[c] = rem_in[c];
          quo_nxt[c] = {quo_in[c][6:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_valid_r[j] <= 1'b0;
      end else if (adv) begin
        dv_valid_r[j] <= valid_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_blend_r[j] <= blend_in;
        dv_pix_r[j]   <= pix_in;
        dv_sum_r[j]   <= sum_in;
        dv_rem_r[j]   <= rem_nxt;
        dv_quo_r[j]   <= quo_nxt;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register: blended colors take the quotients.
  // --------------------------------------------------------------------------
  localparam int LAST = DIV_STAGES - 1;

  logic   out_valid_r;
  pixel_t out_pix_r, out_pix_nxt;

  always_comb begin
    out_pix_nxt = dv_pix_r[LAST];
    if (dv_blend_r[LAST]) begin
      out_pix_nxt.blue  = dv_quo_r[LAST][CH_BLUE];
      out_pix_nxt.green = dv_quo_r[LAST][CH_GREEN];
      out_pix_nxt.red   = dv_quo_r[LAST][CH_RED];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_valid_r[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pix_r <= out_pix_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_blue  = out_pix_r.blue;
  assign out_green = out_pix_r.green;
  assign out_red   = out_pix_r.red;
  assign out_alpha = out_pix_r.alpha;

endmodule

// ===== verif/apng_pixel_blend_over_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// APNG pixel blend-over compositor testbench
// Drives pixel pairs into the compositor, predicts each composited pixel with
// an independent model of the over and source-copy rules, and compares every
// output transfer field by field. Directed corner pixels come first, then
// random traffic in several idle and stall mixes under both blend modes.
// ----------------------------------------------------------------------------
module apng_pixel_blend_over_top_test;
  import apbo_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  cfg_valid = 1'b0;
  logic  cfg_ready;
  logic  cfg_blend_over = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_ready;
  chan_t in_src_blue = '0;
  chan_t in_src_green = '0;
  chan_t in_src_red = '0;
  chan_t in_src_alpha = '0;
  chan_t in_dst_blue = '0;
  chan_t in_dst_green = '0;
  chan_t in_dst_red = '0;
  chan_t in_dst_alpha = '0;
  logic  out_valid;
  logic  out_ready = 1'b1;
  chan_t out_blue;
  chan_t out_green;
  chan_t out_red;
  chan_t out_alpha;

  // Composited pixels still owed by the block, oldest first.
  pixel_t expected_pixels[$];
  // Local copy of the blend_over register.
  logic   blend_mode = 1'b1;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  int     mismatches = 0;
  int     cycles = 0;

  apng_pixel_blend_over_top uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_blend_over (cfg_blend_over),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_src_blue    (in_src_blue),
    .in_src_green   (in_src_green),
    .in_src_red     (in_src_red),
    .in_src_alpha   (in_src_alpha),
    .in_dst_blue    (in_dst_blue),
    .in_dst_green   (in_dst_green),
    .in_dst_red     (in_dst_red),
    .in_dst_alpha   (in_dst_alpha),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_blue       (out_blue),
    .out_green      (out_green),
    .out_red        (out_red),
    .out_alpha      (out_alpha)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // The receiver stalls at random according to the current phase.
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic pixel_t px(input chan_t b, input chan_t g, input chan_t r, input chan_t a);
    pixel_t p;
    p.blue  = b;
    p.green = g;
    p.red   = r;
    p.alpha = a;
    return p;
  endfunction

  // Weighted average of one color channel, truncated.
  function automatic chan_t mix_channel(input chan_t sc, input chan_t dc,
                                        input wgt_t u, input wgt_t v);
    num_t numer;
    numer = num_t'(sc) * num_t'(u) + num_t'(dc) * num_t'(v);
    return chan_t'(numer / num_t'(u + v));
  endfunction

  // Expected canvas pixel after compositing src onto dst.
  function automatic pixel_t composite_over(input pixel_t src, input pixel_t dst,
                                            input logic over);
    wgt_t   u;
    wgt_t   v;
    pixel_t res;
    if (!over || src.alpha == ALPHA_OPAQUE ||
        (src.alpha != ALPHA_CLEAR && dst.alpha == ALPHA_CLEAR))
      return src;
    if (src.alpha == ALPHA_CLEAR)
      return dst;
    u = wgt_t'(src.alpha) * wgt_t'(ALPHA_OPAQUE);
    v = wgt_t'(ALPHA_OPAQUE - src.alpha) * wgt_t'(dst.alpha);
    res.blue  = mix_channel(src.blue, dst.blue, u, v);
    res.green = mix_channel(src.green, dst.green, u, v);
    res.red   = mix_channel(src.red, dst.red, u, v);
    res.alpha = chan_t'((u + v) / wgt_t'(ALPHA_OPAQUE));
    return res;
  endfunction

  // Random channel value with its extremes made likely.
  function automatic chan_t rand_chan();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      default: return chan_t'($urandom_range(255));
    endcase
  endfunction

  // Random alpha weighted toward the codes that pick a rule.
  function automatic chan_t rand_alpha();
    case ($urandom_range(9))
      0: return ALPHA_CLEAR;
      1: return ALPHA_OPAQUE;
      2: return 8'd1;
      3: return 8'd254;
      default: return chan_t'($urandom_range(255));
    endcase
  endfunction

  function automatic pixel_t rand_pixel();
    return px(rand_chan(), rand_chan(), rand_chan(), rand_alpha());
  endfunction

  // Present one pixel pair and hold it until the transfer happens.
  task automatic send_pixel(input pixel_t src, input pixel_t dst);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_src_blue  = src.blue;
    in_src_green = src.green;
    in_src_red   = src.red;
    in_src_alpha = src.alpha;
    in_dst_blue  = dst.blue;
    in_dst_green = dst.green;
    in_dst_red   = dst.red;
    in_dst_alpha = dst.alpha;
    in_valid     = 1'b1;
    do @(posedge clk); while (!in_ready);
    expected_pixels.push_back(composite_over(src, dst, blend_mode));
  endtask

  // Close the input stream and wait for every owed pixel.
  task automatic drain_pipeline();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  // Register write, only with the pipeline empty.
  task automatic write_blend_mode(input logic mode);
    drain_pipeline();
    @(negedge clk);
    cfg_blend_over = mode;
    cfg_valid      = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    blend_mode = mode;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Each rule of the over operator at the reset setting.
  task automatic test_blend_corners();
    send_pixel(px(10, 20, 30, 255), px(200, 100, 50, 128));   // opaque source
    send_pixel(px(255, 255, 255, 0), px(1, 2, 3, 77));        // clear source
    send_pixel(px(9, 8, 7, 0), px(40, 50, 60, 0));            // both clear
    send_pixel(px(90, 80, 70, 128), px(40, 50, 60, 0));       // clear canvas
    send_pixel(px(255, 0, 128, 1), px(0, 255, 64, 255));      // faintest source
    send_pixel(px(3, 250, 17, 254), px(250, 5, 99, 1));       // near-opaque, faint canvas
    send_pixel(px(255, 255, 255, 1), px(0, 0, 0, 1));
    send_pixel(px(255, 255, 255, 128), px(0, 0, 0, 128));
    send_pixel(px(0, 0, 0, 128), px(255, 255, 255, 255));
    send_pixel(px(255, 255, 255, 254), px(255, 255, 255, 255));
    send_pixel(px(12, 34, 56, 255), px(78, 90, 11, 0));
    send_pixel(px(170, 85, 51, 127), px(17, 204, 238, 200));
    send_pixel(px(0, 0, 0, 0), px(0, 0, 0, 0));
    send_pixel(px(255, 255, 255, 255), px(255, 255, 255, 255));
  endtask

  // Source copy passes the frame pixel through whatever the alphas are.
  task automatic test_source_copy();
    write_blend_mode(1'b0);
    send_pixel(px(1, 2, 3, 0), px(4, 5, 6, 200));
    send_pixel(px(77, 66, 55, 128), px(11, 22, 33, 128));
    send_pixel(px(255, 255, 255, 255), px(0, 0, 0, 0));
    send_pixel(px(0, 0, 0, 0), px(255, 255, 255, 255));
    send_pixel(px(200, 100, 50, 1), px(9, 9, 9, 0));
    send_idle_pct  = 17;
    recv_stall_pct = 17;
    repeat (40) send_pixel(rand_pixel(), rand_pixel());
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_blend_mode(1'b1);
  endtask

  // Random blend traffic under one idle and stall mix.
  task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_pixel(rand_pixel(), rand_pixel());
    drain_pipeline();
  endtask

  // Check each output transfer against the oldest expected pixel.
  task automatic check_chan(input string field, input chan_t want, input chan_t got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_results
    pixel_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (expected_pixels.size() == 0) begin
        $error("output transfer with no pixel outstanding");
        mismatches++;
      end else begin
        want = expected_pixels.pop_front();
        check_chan("out_blue", want.blue, out_blue);
        check_chan("out_green", want.green, out_green);
        check_chan("out_red", want.red, out_red);
        check_chan("out_alpha", want.alpha, out_alpha);
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_blend_corners();
    test_source_copy();
    test_random_traffic(100, 0, 0);
    test_random_traffic(100, 68, 0);
    test_random_traffic(100, 0, 68);
    test_random_traffic(100, 17, 17);

    recv_stall_pct = 0;
    drain_pipeline();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_pixels.size() != 0) begin
      $error("%0d composited pixels never arrived", expected_pixels.size());
      mismatches++;
    end

    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
